[src/rld_pkg.sv]
`default_nettype none

package rld_pkg;

   // largest length or offset field that a header may announce
   localparam int unsigned MAX_FIELD_BYTES = 8;

   localparam int unsigned COUNT_WIDTH   = 64;
   localparam int unsigned CLUSTER_WIDTH = 63;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_COUNT,
      PH_DELTA,
      PH_DRAIN
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_END_OK,
      ST_END_EMPTY,
      ST_BAD_HEADER,
      ST_TRUNCATED,
      ST_ZERO_LENGTH,
      ST_OVERFLOW
   } status_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]   cluster_count;
      logic [CLUSTER_WIDTH-1:0] start_cluster;
      logic                     is_sparse;
      status_type               status;
      logic                     last;
   } rld_result_type;

endpackage

`default_nettype wire

[src/rld_req_if.sv]
`default_nettype none

interface rld_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

`default_nettype wire

[src/rld_rsp_if.sv]
`default_nettype none

interface rld_rsp_if import rld_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic [COUNT_WIDTH-1:0]   cluster_count;
   logic [CLUSTER_WIDTH-1:0] start_cluster;
   logic                     is_sparse;
   logic [2:0]               status;
   logic                     last;

   modport source (output valid, output cluster_count, output start_cluster,
                   output is_sparse, output status, output last, input ready);
   modport sink   (input valid, input cluster_count, input start_cluster,
                   input is_sparse, input status, input last, output ready);

endinterface

`default_nettype wire

[src/rld_core.sv]
`default_nettype none

module rld_core import rld_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step_en,
   input  wire logic [7:0]     data_byte,
   input  wire logic           last_byte,
   output logic                result_valid,
   output rld_result_type      result
);

   phase_type                phase_ff, phase_in;
   logic [3:0]               length_bytes_ff, length_bytes_in;
   logic [3:0]               offset_bytes_ff, offset_bytes_in;
   logic [3:0]               byte_index_ff, byte_index_in;
   logic [COUNT_WIDTH-1:0]   count_accum_ff, count_accum_in;
   logic [COUNT_WIDTH-1:0]   delta_accum_ff, delta_accum_in;
   logic [CLUSTER_WIDTH-1:0] current_cluster_ff, current_cluster_in;
   logic                     runs_seen_ff, runs_seen_in;

   logic [3:0]               hdr_len;
   logic [3:0]               hdr_off;
   logic [3:0]               index_next;
   logic [5:0]               byte_shift;
   logic [COUNT_WIDTH-1:0]   byte_placed;
   logic [COUNT_WIDTH-1:0]   count_next;
   logic [COUNT_WIDTH-1:0]   delta_next;
   logic [2:0]               off_top;
   logic                     delta_sign;
   logic [COUNT_WIDTH-1:0]   delta_ext;
   logic [COUNT_WIDTH:0]     cluster_sum;
   logic                     cluster_bad;
   logic                     do_finish;
   status_type               finish_status;
   logic                     do_complete;

   // byte placement into the little-endian accumulators
   assign hdr_len     = data_byte[3:0];
   assign hdr_off     = data_byte[7:4];
   assign index_next  = byte_index_ff + 4'd1;
   assign byte_shift  = {byte_index_ff[2:0], 3'b000};
   assign byte_placed = {{(COUNT_WIDTH-8){1'b0}}, data_byte} << byte_shift;
   assign count_next  = count_accum_ff | byte_placed;
   assign delta_next  = delta_accum_ff | byte_placed;

   // sign extension of the offset field above its top byte
   assign off_top    = 3'(offset_bytes_ff - 4'd1);
   assign delta_sign = delta_next[{off_top, 3'b111}];

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         if (4'(k) >= offset_bytes_ff) begin
            delta_ext[k*8 +: 8] = {8{delta_sign}};
         end else begin
            delta_ext[k*8 +: 8] = delta_next[k*8 +: 8];
         end
      end
   end

   // new position: out of range when the 65-bit sum leaves 0..2^63-1
   assign cluster_sum = {2'b00, current_cluster_ff} + {delta_ext[COUNT_WIDTH-1], delta_ext};
   assign cluster_bad = cluster_sum[COUNT_WIDTH] | cluster_sum[COUNT_WIDTH-1];

   // per-byte step: gather the fields, decide completion or list end
   always_comb begin
      phase_in           = phase_ff;
      length_bytes_in    = length_bytes_ff;
      offset_bytes_in    = offset_bytes_ff;
      byte_index_in      = byte_index_ff;
      count_accum_in     = count_accum_ff;
      delta_accum_in     = delta_accum_ff;
      current_cluster_in = current_cluster_ff;
      runs_seen_in       = runs_seen_ff;
      do_finish          = 1'b0;
      finish_status      = ST_RUN;
      do_complete        = 1'b0;
      result_valid       = 1'b0;
      result             = '0;

      case (phase_ff)
         PH_HEADER: begin
            if (data_byte == 8'd0) begin
               do_finish     = 1'b1;
               finish_status = runs_seen_ff ? ST_END_OK : ST_END_EMPTY;
            end else if (hdr_len == 4'd0 || hdr_len > 4'(MAX_FIELD_BYTES) ||
                         hdr_off > 4'(MAX_FIELD_BYTES)) begin
               do_finish     = 1'b1;
               finish_status = ST_BAD_HEADER;
            end else begin
               length_bytes_in = hdr_len;
               offset_bytes_in = hdr_off;
               byte_index_in   = 4'd0;
               count_accum_in  = '0;
               delta_accum_in  = '0;
               phase_in        = PH_COUNT;
               if (last_byte) begin
                  do_finish     = 1'b1;
                  finish_status = ST_TRUNCATED;
               end
            end
         end
         PH_COUNT: begin
            count_accum_in = count_next;
            byte_index_in  = index_next;
            if (index_next >= length_bytes_ff && offset_bytes_ff == 4'd0) begin
               do_complete = 1'b1;
            end else begin
               if (index_next >= length_bytes_ff) begin
                  phase_in      = PH_DELTA;
                  byte_index_in = 4'd0;
               end
               if (last_byte) begin
                  do_finish     = 1'b1;
                  finish_status = ST_TRUNCATED;
               end
            end
         end
         PH_DELTA: begin
            delta_accum_in = delta_next;
            byte_index_in  = index_next;
            if (index_next >= offset_bytes_ff) begin
               do_complete = 1'b1;
            end else if (last_byte) begin
               do_finish     = 1'b1;
               finish_status = ST_TRUNCATED;
            end
         end
         default: begin
         end
      endcase

      // record complete: zero length, overflow or a run
      if (do_complete) begin
         if (count_accum_in == '0) begin
            do_finish     = 1'b1;
            finish_status = ST_ZERO_LENGTH;
         end else if (offset_bytes_ff != 4'd0 && cluster_bad) begin
            do_finish     = 1'b1;
            finish_status = ST_OVERFLOW;
         end else begin
            result_valid         = 1'b1;
            result.cluster_count = count_accum_in;
            result.status        = ST_RUN;
            result.last          = last_byte;
            if (offset_bytes_ff == 4'd0) begin
               result.is_sparse = 1'b1;
            end else begin
               current_cluster_in   = cluster_sum[CLUSTER_WIDTH-1:0];
               result.start_cluster = cluster_sum[CLUSTER_WIDTH-1:0];
            end
            runs_seen_in  = 1'b1;
            phase_in      = PH_HEADER;
            byte_index_in = 4'd0;
         end
      end

      // list end with a status
      if (do_finish) begin
         result_valid  = 1'b1;
         result        = '0;
         result.status = finish_status;
         result.last   = 1'b1;
         phase_in      = PH_DRAIN;
      end

      // end of buffer returns everything to its reset value
      if (last_byte && (do_finish || do_complete || phase_ff == PH_DRAIN)) begin
         phase_in           = PH_HEADER;
         length_bytes_in    = 4'd0;
         offset_bytes_in    = 4'd0;
         byte_index_in      = 4'd0;
         count_accum_in     = '0;
         delta_accum_in     = '0;
         current_cluster_in = '0;
         runs_seen_in       = 1'b0;
      end

      if (!step_en) begin
         result_valid = 1'b0;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HEADER;
         length_bytes_ff    <= 4'd0;
         offset_bytes_ff    <= 4'd0;
         byte_index_ff      <= 4'd0;
         count_accum_ff     <= '0;
         delta_accum_ff     <= '0;
         current_cluster_ff <= '0;
         runs_seen_ff       <= 1'b0;
      end else if (step_en) begin
         phase_ff           <= phase_in;
         length_bytes_ff    <= length_bytes_in;
         offset_bytes_ff    <= offset_bytes_in;
         byte_index_ff      <= byte_index_in;
         count_accum_ff     <= count_accum_in;
         delta_accum_ff     <= delta_accum_in;
         current_cluster_ff <= current_cluster_in;
         runs_seen_ff       <= runs_seen_in;
      end
   end

   // checks
   a_index_in_field: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= 4'(MAX_FIELD_BYTES))
      else $error("byte index past the largest field");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      result_valid && result.status != ST_RUN |->
         result.cluster_count == '0 && result.start_cluster == '0 && !result.is_sparse)
      else $error("error result carries run fields");

   a_sparse_no_start: assert property (@(posedge clock) disable iff (reset)
      result_valid && result.is_sparse |-> result.start_cluster == '0)
      else $error("sparse run with a start cluster");

   a_drain_after_end: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DRAIN && $past(phase_ff) != PH_DRAIN |->
         $past(result_valid && result.last))
      else $error("drain entered without a final result");

endmodule

`default_nettype wire

[src/ntfs_run_list_decoder.sv]
// an accepted byte passes the input register and then the result register before its result reaches rsp_bus
// throughput: one byte per cycle while rsp_bus.ready stays high
// the rate is set by one pass of the byte step (one 65-bit add) between
// the input register and the result register
// reset (synchronous, active high) empties both registers and returns the
// decoder to waiting for a header byte with a zero cluster position
`default_nettype none

module ntfs_run_list_decoder import rld_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   rld_req_if.sink   req_bus,
   rld_rsp_if.source rsp_bus
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   logic           out_valid_ff, out_valid_in;
   rld_result_type out_result_ff;
   logic           out_free;
   logic           step_fire;
   logic           step_valid;
   rld_result_type step_result;

   // handshake between input register, step and result register
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign step_fire     = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;

   assign in_valid_in  = req_bus.valid ? 1'b1 : (in_valid_ff && !step_fire);
   assign out_valid_in = step_fire ? step_valid : (out_valid_ff && !rsp_bus.ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   rld_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_fire),
      .data_byte    (in_byte_ff),
      .last_byte    (in_last_ff),
      .result_valid (step_valid),
      .result       (step_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire && step_valid) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.cluster_count = out_result_ff.cluster_count;
   assign rsp_bus.start_cluster = out_result_ff.start_cluster;
   assign rsp_bus.is_sparse     = out_result_ff.is_sparse;
   assign rsp_bus.status        = out_result_ff.status;
   assign rsp_bus.last          = out_result_ff.last;

   // checks
   a_held_while_blocked: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("input byte lost while the result register was full");

   a_result_from_step: assert property (@(posedge clock) disable iff (reset)
      !$past(out_valid_ff) && out_valid_ff |-> $past(step_fire && step_valid))
      else $error("result appeared without a step");

   a_no_step_when_full: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_bus.ready |-> !step_fire)
      else $error("step fired into a full result register");

endmodule

`default_nettype wire

[test/ntfs_run_list_decoder_test.sv]
`default_nettype none

module ntfs_run_list_decoder_test import rld_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 400;
   localparam int DRAIN_CYCLES   = 10;
   localparam int RANDOM_BYTES   = 1150;
   localparam int QUIET_TAIL     = 120;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } run_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rld_req_if req_bus ();
   rld_rsp_if rsp_bus ();

   ntfs_run_list_decoder DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #6 clock = ~clock;

   // bytes still to be sent and runs still to be seen
   run_byte_type   pending_bytes[$];
   rld_result_type expected_runs[$];
   run_byte_type   next_byte;
   int             accepted_bytes = 0;
   int             total_bytes    = 0;
   int             mismatches     = 0;
   int             send_hold      = 0;
   int             sink_hold      = 0;
   int             quiet_cycles   = 0;

   // decoder image: list position and the record being gathered
   phase_type   dec_phase;
   logic [3:0]  len_size;
   logic [3:0]  ofs_size;
   logic [3:0]  field_pos;
   logic [63:0] count_acc;
   logic [63:0] delta_acc;
   logic [62:0] cluster_pos;
   logic        seen_run;

   function automatic logic [63:0] sign_extend(input logic [63:0] raw, input int nbytes);
      logic [63:0] v;
      v = raw;
      if (nbytes > 0 && nbytes < 8 && raw[nbytes*8-1])
         v = raw | (~64'd0 << (nbytes * 8));
      return v;
   endfunction

   // true when pos + delta stays in 0..2^63-1
   function automatic bit position_fits(input logic [63:0] pos, input logic [63:0] delta);
      logic [63:0] s;
      s = pos + delta;
      if (!delta[63])
         return !s[63];
      return (~delta + 64'd1) <= pos;
   endfunction

   function automatic logic [63:0] random_field(input int nbytes);
      logic [63:0] v;
      v = {$urandom, $urandom};
      if (nbytes < 8)
         v = v & ((64'd1 << (nbytes * 8)) - 64'd1);
      return v;
   endfunction

   task automatic clear_decoder();
      dec_phase   = PH_HEADER;
      len_size    = '0;
      ofs_size    = '0;
      field_pos   = '0;
      count_acc   = '0;
      delta_acc   = '0;
      cluster_pos = '0;
      seen_run    = 1'b0;
   endtask

   // list over: status only, then drain until the buffer ends
   task automatic end_list(input status_type st, input logic lb);
      rld_result_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      expected_runs.insert(expected_runs.size(), r);
      if (lb)
         clear_decoder();
      else
         dec_phase = PH_DRAIN;
   endtask

   task automatic close_record(input logic lb);
      rld_result_type r;
      logic [63:0]    d;
      logic [63:0]    s;
      bit             fits;
      fits = 1'b1;
      r = '0;
      if (count_acc == 64'd0) begin
         end_list(ST_ZERO_LENGTH, lb);
      end else begin
         if (ofs_size == 4'd0) begin
            r.is_sparse = 1'b1;
         end else begin
            d = sign_extend(delta_acc, int'(ofs_size));
            fits = position_fits({1'b0, cluster_pos}, d);
            if (fits) begin
               s = {1'b0, cluster_pos} + d;
               cluster_pos = s[62:0];
            end
            r.start_cluster = cluster_pos;
         end
         if (!fits) begin
            end_list(ST_OVERFLOW, lb);
         end else begin
            seen_run = 1'b1;
            r.cluster_count = count_acc;
            r.status = ST_RUN;
            r.last = lb;
            expected_runs.insert(expected_runs.size(), r);
            if (lb) begin
               clear_decoder();
            end else begin
               dec_phase = PH_HEADER;
               field_pos = '0;
            end
         end
      end
   endtask

   // expected results of one accepted byte
   task automatic decode_byte(input logic [7:0] b, input logic lb);
      bit closed;
      closed = 1'b0;
      case (dec_phase)
         PH_HEADER: begin
            if (b == 8'h00) begin
               end_list(seen_run ? ST_END_OK : ST_END_EMPTY, lb);
            end else if (b[3:0] == 4'd0 || b[3:0] > MAX_FIELD_BYTES ||
                         b[7:4] > MAX_FIELD_BYTES) begin
               end_list(ST_BAD_HEADER, lb);
            end else begin
               len_size  = b[3:0];
               ofs_size  = b[7:4];
               field_pos = '0;
               count_acc = '0;
               delta_acc = '0;
               dec_phase = PH_COUNT;
               if (lb)
                  end_list(ST_TRUNCATED, lb);
            end
         end
         PH_COUNT: begin
            count_acc = count_acc | (64'(b) << {field_pos[2:0], 3'b000});
            field_pos = field_pos + 4'd1;
            if (field_pos >= len_size) begin
               if (ofs_size == 4'd0) begin
                  close_record(lb);
                  closed = 1'b1;
               end else begin
                  dec_phase = PH_DELTA;
                  field_pos = '0;
               end
            end
            if (!closed && lb)
               end_list(ST_TRUNCATED, lb);
         end
         PH_DELTA: begin
            delta_acc = delta_acc | (64'(b) << {field_pos[2:0], 3'b000});
            field_pos = field_pos + 4'd1;
            if (field_pos >= ofs_size)
               close_record(lb);
            else if (lb)
               end_list(ST_TRUNCATED, lb);
         end
         default: begin
            if (lb)
               clear_decoder();
         end
      endcase
   endtask

   task automatic add_item(input logic [7:0] b, input logic lb);
      run_byte_type t;
      t.data_byte = b;
      t.last_byte = lb;
      pending_bytes.insert(pending_bytes.size(), t);
   endtask

   task automatic push_field(input logic [63:0] value, input int nbytes);
      for (int i = 0; i < nbytes; i++)
         add_item(value[8*i +: 8], 1'b0);
   endtask

   // well-formed run list with random content and a random ending
   task automatic build_list();
      int          runs;
      int          ending;
      int          lsz;
      int          osz;
      int          cut;
      int          pad;
      logic [63:0] pos;
      logic [63:0] cnt;
      logic [63:0] raw;
      pos = '0;
      runs = $urandom_range(0, 6);
      ending = $urandom_range(0, 9);
      lsz = 1;
      osz = 0;
      for (int r = 0; r < runs; r++) begin
         lsz = $urandom_range(1, 8);
         osz = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
         cnt = random_field(lsz);
         if (cnt == 64'd0)
            cnt = 64'd1;
         raw = random_field(osz);
         // steer the delta so the position stays legal
         if (osz != 0 && !position_fits(pos, sign_extend(raw, osz))) begin
            raw = (~sign_extend(raw, osz) + 64'd1);
            if (osz < 8)
               raw = raw & ((64'd1 << (osz * 8)) - 64'd1);
            if (!position_fits(pos, sign_extend(raw, osz)))
               raw = '0;
         end
         if (osz != 0)
            pos = pos + sign_extend(raw, osz);
         add_item(8'(osz * 16 + lsz), 1'b0);
         push_field(cnt, lsz);
         push_field(raw, osz);
      end
      if (ending == 7 && runs > 0) begin
         // last run closes the buffer
         pending_bytes[$].last_byte = 1'b1;
      end else if (ending == 8 && runs > 0) begin
         // buffer stops inside the last record
         cut = $urandom_range(1, lsz + osz);
         repeat (cut) void'(pending_bytes.pop_back());
         pending_bytes[$].last_byte = 1'b1;
      end else begin
         if (ending == 9) begin
            case ($urandom_range(0, 2))
               0: begin
                  case ($urandom_range(0, 2))
                     0: add_item({4'($urandom_range(1, 15)), 4'h0}, 1'b0);
                     1: add_item({4'($urandom_range(0, 8)), 4'($urandom_range(9, 15))}, 1'b0);
                     default: add_item({4'($urandom_range(9, 15)), 4'($urandom_range(1, 8))},
                                       1'b0);
                  endcase
               end
               1: begin
                  lsz = $urandom_range(1, 8);
                  osz = $urandom_range(0, 8);
                  add_item(8'(osz * 16 + lsz), 1'b0);
                  push_field(64'd0, lsz);
                  push_field(random_field(osz), osz);
               end
               default: begin
                  lsz = $urandom_range(1, 8);
                  add_item(8'(8 * 16 + lsz), 1'b0);
                  push_field(random_field(lsz) | 64'd1, lsz);
                  push_field(64'h8000_0000_0000_0000 | ($urandom_range(0, 1) ?
                             64'd0 : {$urandom, $urandom} >> 1), 8);
               end
            endcase
         end else begin
            add_item(8'h00, 1'b0);
         end
         pad = $urandom_range(0, 5);
         repeat (pad) add_item(8'($urandom), 1'b0);
         pending_bytes[$].last_byte = 1'b1;
      end
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.data_byte <= 8'h00;
         req_bus.last_byte <= 1'b0;
         send_hold = 0;
         clear_decoder();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.data_byte, req_bus.last_byte);
            accepted_bytes++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_hold > 0) begin
               send_hold--;
               req_bus.valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               next_byte = pending_bytes.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.data_byte <= next_byte.data_byte;
               req_bus.last_byte <= next_byte.last_byte;
               if (pending_bytes.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
                  send_hold = $urandom_range(1, 16);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rld_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_runs.size() == 0) begin
               $display("%0t unexpected result: expected none, ", $time,
                        "actual count %h start %h sparse %b status %0d last %b",
                        rsp_bus.cluster_count, rsp_bus.start_cluster,
                        rsp_bus.is_sparse, rsp_bus.status, rsp_bus.last);
               mismatches++;
            end else begin
               want = expected_runs.pop_front();
               if (rsp_bus.cluster_count !== want.cluster_count) begin
                  $display("%0t cluster_count: expected %h, actual %h", $time,
                           want.cluster_count, rsp_bus.cluster_count);
                  mismatches++;
               end
               if (rsp_bus.start_cluster !== want.start_cluster) begin
                  $display("%0t start_cluster: expected %h, actual %h", $time,
                           want.start_cluster, rsp_bus.start_cluster);
                  mismatches++;
               end
               if (rsp_bus.is_sparse !== want.is_sparse) begin
                  $display("%0t is_sparse: expected %b, actual %b", $time,
                           want.is_sparse, rsp_bus.is_sparse);
                  mismatches++;
               end
               if (rsp_bus.status !== want.status) begin
                  $display("%0t status: expected %0d, actual %0d", $time,
                           want.status, rsp_bus.status);
                  mismatches++;
               end
               if (rsp_bus.last !== want.last) begin
                  $display("%0t last: expected %b, actual %b", $time,
                           want.last, rsp_bus.last);
                  mismatches++;
               end
            end
         end
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (pending_bytes.size() >= QUIET_TAIL && $urandom_range(0, 11) == 0)
               sink_hold = $urandom_range(1, 16);
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;

      // directed: empty list
      add_item(8'h00, 1'b1);
      // run with delta, sparse run, zero header ends the list
      add_item(8'h11, 1'b0);
      add_item(8'hFF, 1'b0);
      add_item(8'h7F, 1'b0);
      add_item(8'h01, 1'b0);
      add_item(8'h05, 1'b0);
      add_item(8'h00, 1'b1);
      // bad headers: offset size too big, length size too big, length size zero
      add_item(8'h91, 1'b1);
      add_item(8'h09, 1'b0);
      add_item(8'hAB, 1'b1);
      add_item(8'h30, 1'b1);
      // zero length
      add_item(8'h11, 1'b0);
      add_item(8'h00, 1'b0);
      add_item(8'h01, 1'b1);
      // negative delta from cluster zero overflows
      add_item(8'h11, 1'b0);
      add_item(8'h01, 1'b0);
      add_item(8'hFF, 1'b1);
      // buffer ends right after a header
      add_item(8'h21, 1'b1);
      // widest count, sparse run that closes the buffer
      add_item(8'h08, 1'b0);
      for (int i = 0; i < 8; i++)
         add_item(8'hFF, i == 7);

      // random lists and noise
      while (pending_bytes.size() < RANDOM_BYTES + 25) begin
         if ($urandom_range(0, 99) < 85) begin
            build_list();
         end else begin
            repeat ($urandom_range(0, 11)) add_item(8'($urandom), 1'b0);
            add_item(8'($urandom), 1'b1);
         end
      end
      total_bytes = pending_bytes.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (accepted_bytes < total_bytes || expected_runs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_runs.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
